### rtl/aabb_accumulate_and_transform_unit_assert.svh
// Assertion macros shared by the block's RTL.
`ifndef AABB_ACCUMULATE_AND_TRANSFORM_UNIT_ASSERT_SVH
`define AABB_ACCUMULATE_AND_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/aat_pkg.sv
package aat_pkg;

  localparam int OP_WIDTH   = 2;
  localparam int AXIS_WIDTH = 2;
  localparam int NUM_AXES   = 3;

  typedef logic [OP_WIDTH-1:0]   op_t;
  typedef logic [AXIS_WIDTH-1:0] axis_t;

  // Item codes
  localparam op_t OP_CLEAR     = 2'd0;
  localparam op_t OP_VERTEX    = 2'd1;
  localparam op_t OP_TRANSFORM = 2'd2;

endpackage

### rtl/aat_if.sv
interface aat_in_if
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  op_t                           operation;
  axis_t                         axis;
  logic signed [COORD_WIDTH-1:0] first_value;
  logic signed [COORD_WIDTH-1:0] second_value;
  logic signed [COORD_WIDTH-1:0] third_value;
  logic signed [COORD_WIDTH-1:0] offset_value;

  modport source (
    output valid, operation, axis, first_value, second_value, third_value, offset_value,
    input  ready
  );
  modport sink (
    input  valid, operation, axis, first_value, second_value, third_value, offset_value,
    output ready
  );
endinterface

interface aat_out_if
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  axis_t                         out_axis;
  logic signed [COORD_WIDTH-1:0] low_bound;
  logic signed [COORD_WIDTH-1:0] high_bound;
  logic                          box_was_empty;

  modport source (
    output valid, out_axis, low_bound, high_bound, box_was_empty,
    input  ready
  );
  modport sink (
    input  valid, out_axis, low_bound, high_bound, box_was_empty,
    output ready
  );
endinterface

### rtl/aabb_accumulate_and_transform_unit.sv
// Axis-aligned box accumulator with affine box transform. Each input beat is
// a clear (empties the box), a vertex (widens the per-axis minimum and maximum
// to take it in) or one transform row: three coefficients and a translation
// for one output axis, answered by one result beat holding that axis' low and
// high bounds of the transformed box, worked out by picking, per source axis,
// the smaller and larger of coefficient*min and coefficient*max. Values are
// signed fixed point, COORD_WIDTH bits with FRAC_BITS fraction bits (Q16.16 by
// default); products are floored and saturated, and each bound saturates once
// after the four-term sum. Clear and vertex beats give no result, nor does the
// unused operation code. A beat is held in one input stage register, and a
// transform row's result in one result register; six parallel multipliers sit
// between the two. A new beat is taken every cycle unless the stage holds a
// transform row while an earlier result still waits to be taken. A transform
// row sees the box as left by every beat accepted before it. Axis 3 is not
// rejected: it is echoed with bounds computed like any other row.
`include "aabb_accumulate_and_transform_unit_assert.svh"

module aabb_accumulate_and_transform_unit
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aat_in_if.sink     in_ch,
  aat_out_if.source  out_ch
);

  localparam int PW = 2 * COORD_WIDTH;   // exact product width
  localparam int SW = COORD_WIDTH + 2;   // four-term sum width

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Floor a full product down to the fixed-point grid, then clamp.
  function automatic coord_t sat_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    if (s > PW'(C_MAX)) begin
      return C_MAX;
    end else if (s < PW'(C_MIN)) begin
      return C_MIN;
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t sat_sum(input logic signed [SW-1:0] v);
    if (v > SW'(C_MAX)) begin
      return C_MAX;
    end else if (v < SW'(C_MIN)) begin
      return C_MIN;
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input stage: hold one beat; advance when its effect can be applied.
  // ---------------------------------------------------------------------------
  logic   s_valid_r;
  op_t    s_op_r;
  axis_t  s_axis_r;
  coord_t s_val_r [NUM_AXES];
  coord_t s_off_r;

  logic   adv;
  logic   in_take;
  logic   out_valid_r;

  assign adv     = s_valid_r && ((s_op_r != OP_TRANSFORM) || !out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_op_r     <= in_ch.operation;
      s_axis_r   <= in_ch.axis;
      s_val_r[0] <= in_ch.first_value;
      s_val_r[1] <= in_ch.second_value;
      s_val_r[2] <= in_ch.third_value;
      s_off_r    <= in_ch.offset_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Box state, updated as each stage beat advances.
  // ---------------------------------------------------------------------------
  coord_t min_r   [NUM_AXES];
  coord_t max_r   [NUM_AXES];
  coord_t min_nxt [NUM_AXES];
  coord_t max_nxt [NUM_AXES];
  logic   empty_r;
  logic   empty_nxt;

  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    empty_nxt = empty_r;
    if (adv) begin
      case (s_op_r)
        OP_CLEAR: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            min_nxt[i] = C_MAX;
            max_nxt[i] = C_MIN;
          end
          empty_nxt = 1'b1;
        end
        OP_VERTEX: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (s_val_r[i] < min_r[i]) min_nxt[i] = s_val_r[i];
            if (s_val_r[i] > max_r[i]) max_nxt[i] = s_val_r[i];
          end
          empty_nxt = 1'b0;
        end
        default: begin
          // transform rows read the box only; the spare code is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        min_r[i] <= C_MAX;
        max_r[i] <= C_MIN;
      end
      empty_r <= 1'b1;
    end else begin
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      empty_r <= empty_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Transform row: per source axis, two floored products, ordered, then summed
  // with the translation and clamped.
  // ---------------------------------------------------------------------------
  coord_t lo_term [NUM_AXES];
  coord_t hi_term [NUM_AXES];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    logic signed [PW-1:0] prod_min;
    logic signed [PW-1:0] prod_max;
    coord_t               p;
    coord_t               q;

    assign prod_min = PW'(s_val_r[g]) * PW'(min_r[g]);
    assign prod_max = PW'(s_val_r[g]) * PW'(max_r[g]);
    assign p        = sat_prod(prod_min);
    assign q        = sat_prod(prod_max);
    assign lo_term[g] = (p < q) ? p : q;
    assign hi_term[g] = (p < q) ? q : p;
  end

  logic signed [SW-1:0] low_sum;
  logic signed [SW-1:0] high_sum;

  assign low_sum  = SW'(s_off_r) + SW'(lo_term[0]) + SW'(lo_term[1]) + SW'(lo_term[2]);
  assign high_sum = SW'(s_off_r) + SW'(hi_term[0]) + SW'(hi_term[1]) + SW'(hi_term[2]);

  // ---------------------------------------------------------------------------
  // Result register: load on a transform beat, drop the beat once taken.
  // ---------------------------------------------------------------------------
  logic   out_load;
  logic   out_valid_nxt;
  axis_t  out_axis_r;
  coord_t low_r;
  coord_t high_r;
  logic   was_empty_r;

  assign out_load      = adv && (s_op_r == OP_TRANSFORM);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_axis_r  <= s_axis_r;
      low_r       <= sat_sum(low_sum);
      high_r      <= sat_sum(high_sum);
      was_empty_r <= empty_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_axis      = out_axis_r;
  assign out_ch.low_bound     = low_r;
  assign out_ch.high_bound    = high_r;
  assign out_ch.box_was_empty = was_empty_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `AAT_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready, !out_load, "result overwritten while pending")
  `AAT_ASSERT_NEXT(a_vertex_fills, clk, rst_n, adv && (s_op_r == OP_VERTEX), !empty_r, "box still empty after a vertex")
  `AAT_ASSERT_NEXT(a_clear_empties, clk, rst_n, adv && (s_op_r == OP_CLEAR), empty_r && (min_r[0] == C_MAX) && (max_r[2] == C_MIN), "box not emptied by clear")
  `AAT_ASSERT_NOW(a_box_ordered, clk, rst_n, !empty_r, (min_r[0] <= max_r[0]) && (min_r[1] <= max_r[1]) && (min_r[2] <= max_r[2]), "filled box has min above max")

endmodule
